// ===== sv/pwdp_pkg.sv =====
// ----------------------------------------------------------------------------
// pwdp_pkg
// Shared constants, control struct and binary32 helper functions for the
// power-of-two weight dot product accumulator.
// ----------------------------------------------------------------------------
package pwdp_pkg;

  localparam int unsigned Lanes   = 16;
  localparam int unsigned Pairs   = Lanes / 2;
  localparam int unsigned Wide    = 32;
  localparam int unsigned ManBits = 23;

  localparam logic [31:0] SignBit  = 32'h8000_0000;
  localparam logic [30:0] InfMag   = 31'h7F80_0000;
  localparam logic [31:0] DefNan   = 32'hFFC0_0000;
  localparam logic [7:0]  CodeMax  = 8'h1F;
  localparam logic [7:0]  CodeFlip = 8'h20;

  // control flags that travel with a word into the reduction tree
  typedef struct packed {
    logic vld;
    logic last;
  } ctl_t;

  // power-of-two scaling of one activation by its weight code
  function automatic logic [31:0] pot_term(input logic [31:0] act, input logic [7:0] code);
    logic        neg;
    logic [7:0]  cs;
    logic [31:0] t;
    begin
      neg = !code[7] && (code > CodeMax);
      cs  = neg ? (code - CodeFlip) : code;
      t   = act;
      if (act[30:0] != InfMag) begin
        // sign-extended code lands in bits 31:23
        t = act + {cs[7], cs, {ManBits{1'b0}}};
      end
      if (neg) begin
        t = t ^ SignBit;
      end
      pot_term = t;
    end
  endfunction

  // binary32 add, round to nearest even, subnormals kept
  function automatic logic [31:0] fadd32(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]  ea;
    logic [7:0]  eb;
    logic [22:0] ma;
    logic [22:0] mb;
    logic [31:0] big;
    logic [31:0] sml;
    logic        sgn;
    logic [9:0]  e;
    logic [7:0]  e2;
    logic [7:0]  d;
    logic [27:0] sa;
    logic [27:0] sb;
    logic [27:0] msk;
    logic [4:0]  lz;
    logic [9:0]  sh;
    logic [2:0]  low;
    logic [24:0] m;
    logic [31:0] res;
    begin
      ea  = a[30:23];
      eb  = b[30:23];
      ma  = a[22:0];
      mb  = b[22:0];
      big = 32'd0;
      sml = 32'd0;
      sgn = 1'b0;
      e   = 10'd0;
      e2  = 8'd0;
      d   = 8'd0;
      sa  = 28'd0;
      sb  = 28'd0;
      msk = 28'd0;
      lz  = 5'd27;
      sh  = 10'd0;
      low = 3'd0;
      m   = 25'd0;
      res = 32'd0;
      if (ea == 8'hFF && ma != 23'd0) begin
        res = a | 32'h0040_0000;
      end else if (eb == 8'hFF && mb != 23'd0) begin
        res = b | 32'h0040_0000;
      end else if (ea == 8'hFF) begin
        res = (eb == 8'hFF && a[31] != b[31]) ? DefNan : a;
      end else if (eb == 8'hFF) begin
        res = b;
      end else if (a[30:0] == 31'd0 && b[30:0] == 31'd0) begin
        res = (a == b) ? a : 32'd0;
      end else if (a[30:0] == 31'd0) begin
        res = b;
      end else if (b[30:0] == 31'd0) begin
        res = a;
      end else begin
        if (a[30:0] >= b[30:0]) begin
          big = a;
          sml = b;
        end else begin
          big = b;
          sml = a;
        end
        sgn = big[31];
        e   = {2'b00, big[30:23]};
        e2  = sml[30:23];
        sa  = {5'd0, big[22:0]};
        sb  = {5'd0, sml[22:0]};
        if (e == 10'd0) e = 10'd1; else sa[23] = 1'b1;
        if (e2 == 8'd0) e2 = 8'd1; else sb[23] = 1'b1;
        sa = sa << 3;
        sb = sb << 3;
        d  = e[7:0] - e2;
        if (d >= 8'd27) begin
          sb = {27'd0, (sb != 28'd0)};
        end else if (d != 8'd0) begin
          msk = (28'd1 << d) - 28'd1;
          sb  = (sb >> d) | {27'd0, ((sb & msk) != 28'd0)};
        end
        if (a[31] == b[31]) begin
          sa = sa + sb;
          if (sa[27]) begin
            sa = (sa >> 1) | {27'd0, sa[0]};
            e  = e + 10'd1;
          end
        end else begin
          sa = sa - sb;
          for (int i = 0; i < 27; i++) begin
            if (sa[i]) lz = 5'(26 - i);
          end
          sh = (10'(lz) < (e - 10'd1)) ? 10'(lz) : (e - 10'd1);
          sa = sa << sh;
          e  = e - sh;
        end
        if (sa == 28'd0) begin
          res = 32'd0;
        end else begin
          low = sa[2:0];
          m   = sa[27:3];
          if (low > 3'd4 || (low == 3'd4 && m[0])) m = m + 25'd1;
          if (m[24]) begin
            m = m >> 1;
            e = e + 10'd1;
          end
          if (e >= 10'd255) begin
            res = {sgn, 8'hFF, 23'd0};
          end else begin
            if (!m[23]) e = 10'd0;
            res = {sgn, e[7:0], m[22:0]};
          end
        end
      end
      fadd32 = res;
    end
  endfunction

endpackage

// ===== sv/pot_weight_dot_product_accumulator.sv =====
// ----------------------------------------------------------------------------
// pot_weight_dot_product_accumulator
// Sixteen-lane dot product of binary32 activations with power-of-two weights.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | input     | in_valid_i / in_stall_o     | act_pair_0..7, codes, tile_end, last
//  out     | output    | out_valid_o / out_stall_i   | dot_sum_o
//
//  One word is taken per cycle while in_stall_o is low; each lane add is a
//  single-register loop. A tile_end or last word enters a six-stage reduction
//  pipeline (snapshot, three tree levels, final add, total add); out_valid_o
//  rises when the result of a last word reaches the output register.
//  Reset clears lanes, total and all valid flags.
//  While the output register holds an unread word under stall, the whole
//  datapath freezes and in_stall_o is raised.
// ----------------------------------------------------------------------------
module pot_weight_dot_product_accumulator
  import pwdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] act_pair_0_i,
  input  logic [63:0] act_pair_1_i,
  input  logic [63:0] act_pair_2_i,
  input  logic [63:0] act_pair_3_i,
  input  logic [63:0] act_pair_4_i,
  input  logic [63:0] act_pair_5_i,
  input  logic [63:0] act_pair_6_i,
  input  logic [63:0] act_pair_7_i,
  input  logic [63:0] codes_low_i,
  input  logic [63:0] codes_high_i,
  input  logic        tile_end_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] dot_sum_o
);

  logic        adv;
  logic        take;
  logic        clr;
  ctl_t        ctl;
  logic [63:0] pairs [Pairs];
  logic [127:0] codes;
  logic [31:0] lane_sum [Lanes];

  // global advance: hold everything while a result waits under stall
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;
  assign take       = in_valid_i && adv;
  assign clr        = tile_end_i || last_i;
  assign ctl.vld    = take && clr;
  assign ctl.last   = last_i;

  assign pairs[0] = act_pair_0_i;
  assign pairs[1] = act_pair_1_i;
  assign pairs[2] = act_pair_2_i;
  assign pairs[3] = act_pair_3_i;
  assign pairs[4] = act_pair_4_i;
  assign pairs[5] = act_pair_5_i;
  assign pairs[6] = act_pair_6_i;
  assign pairs[7] = act_pair_7_i;
  assign codes    = {codes_high_i, codes_low_i};

  for (genvar g = 0; g < Lanes; g++) begin : g_lane
    pwdp_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .take_i (take),
      .clr_i  (clr),
      .act_i  (pairs[g/2][(g%2)*Wide +: Wide]),
      .code_i (codes[g*8 +: 8]),
      .sum_o  (lane_sum[g])
    );
  end

  // lane sums are snapshotted into the tree; those of a tile_end or last word are marked valid
  pwdp_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .ctl_i       (ctl),
    .lane_i      (lane_sum),
    .res_valid_o (out_valid_o),
    .res_data_o  (dot_sum_o)
  );

endmodule

// ===== sv/pwdp_lane.sv =====
// ----------------------------------------------------------------------------
// pwdp_lane
// One lane: scales its activation by the weight code and accumulates; a take with clr_i clears it.
// ----------------------------------------------------------------------------
module pwdp_lane
  import pwdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic        clr_i,
  input  logic [31:0] act_i,
  input  logic [7:0]  code_i,
  output logic [31:0] sum_o
);

  logic [31:0] acc_q;
  logic [31:0] acc_d;

  assign sum_o = fadd32(acc_q, pot_term(act_i, code_i));

  always_comb begin
    acc_d = acc_q;
    if (take_i) begin
      acc_d = clr_i ? 32'd0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= 32'd0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

// ===== sv/pwdp_reduce.sv =====
// ----------------------------------------------------------------------------
// pwdp_reduce
// Registered reduction tree over the lane sums, running total and result.
// ----------------------------------------------------------------------------
module pwdp_reduce
  import pwdp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  ctl_t        ctl_i,
  input  logic [31:0] lane_i [Lanes],
  output logic        res_valid_o,
  output logic [31:0] res_data_o
);

  ctl_t        c0_q, c1_q, c2_q, c3_q, c4_q;
  logic [31:0] s0_q [Lanes];
  logic [31:0] w_q  [Pairs];
  logic [31:0] x_q  [Pairs/2];
  logic [31:0] y_q  [2];
  logic [31:0] r_q;
  logic [31:0] tot_q;
  logic [31:0] tot_sum;
  logic        res_valid_q;
  logic [31:0] res_data_q;

  assign tot_sum     = fadd32(tot_q, r_q);
  assign res_valid_o = res_valid_q;
  assign res_data_o  = res_data_q;

  // control and total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c0_q        <= '0;
      c1_q        <= '0;
      c2_q        <= '0;
      c3_q        <= '0;
      c4_q        <= '0;
      tot_q       <= 32'd0;
      res_valid_q <= 1'b0;
    end else if (adv_i) begin
      c0_q        <= ctl_i;
      c1_q        <= c0_q;
      c2_q        <= c1_q;
      c3_q        <= c2_q;
      c4_q        <= c3_q;
      res_valid_q <= c4_q.vld && c4_q.last;
      if (c4_q.vld) begin
        tot_q <= c4_q.last ? 32'd0 : tot_sum;
      end
    end
  end

  // tree data
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      for (int i = 0; i < Lanes; i++) s0_q[i] <= lane_i[i];
      for (int i = 0; i < Pairs; i++) w_q[i] <= fadd32(s0_q[i], s0_q[i+Pairs]);
      for (int i = 0; i < Pairs/2; i++) x_q[i] <= fadd32(w_q[i], w_q[i+Pairs/2]);
      y_q[0]     <= fadd32(x_q[0], x_q[1]);
      y_q[1]     <= fadd32(x_q[2], x_q[3]);
      r_q        <= fadd32(y_q[0], y_q[1]);
      res_data_q <= tot_sum;
    end
  end

endmodule
